@@ design/aes_pkg.sv @@
// Package for the AES block encryptor: byte/state types, S-box table,
// GF(2^8) helpers and round functions. No dependencies.
`timescale 1ns / 1ps
package aes_pkg;

  localparam int unsigned NumStages = 15;  // initial key add + up to 14 rounds
  localparam int unsigned CfgIdxWidth = 3;

  typedef logic [127:0] block_t;
  typedef logic [7:0]   byte_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_KEY_MODE  = 3'd0,
    REG_KEY_WORD0 = 3'd1,
    REG_KEY_WORD1 = 3'd2,
    REG_KEY_WORD2 = 3'd3,
    REG_KEY_WORD3 = 3'd4
  } cfg_reg_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t xtime(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte i of the block sits at bits 127-8i
  function automatic byte_t get_byte(block_t s, int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  function automatic block_t sub_shift(block_t s);
    block_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
      end
    end
    return o;
  endfunction

  function automatic block_t mix_columns(block_t s);
    block_t o;
    byte_t a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      o[127-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      o[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      o[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      o[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return o;
  endfunction

endpackage

@@ design/aes_if.sv @@
// Channel interfaces for the AES block encryptor: data in, data out, config.
// Depends on nothing.
`timescale 1ns / 1ps
interface aes_plain_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, plain_high, plain_low, input ready);
  modport sink (input valid, plain_high, plain_low, output ready);
endinterface

interface aes_cipher_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  modport source (output valid, cipher_high, cipher_low, input ready);
  modport sink (input valid, cipher_high, cipher_low, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/aes_key_sched.sv @@
// Key register file and round-key expansion for AES-128/256.
// Depends on aes_pkg, aes_if. Round keys are rebuilt after reset and each config write.
`timescale 1ns / 1ps
module aes_key_sched
  import aes_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  aes_cfg_if.sink        cfg,
  output logic           key_mode,
  output logic           key_ready,
  output block_t         round_keys [NumStages]
);

  logic [63:0] key_word [4];
  logic [31:0] win [8];
  logic [5:0]  widx;
  logic        busy;
  byte_t       rc;
  logic [31:0] key_w;
  logic [31:0] t;
  logic [31:0] word;
  logic        first_word;
  logic        rot_step;
  logic        sub_step;
  logic        done_step;

  assign cfg.ready = 1'b1;
  assign key_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode <= 1'b0;
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KEY_MODE:  key_mode    <= cfg.data[0];
        REG_KEY_WORD0: key_word[0] <= cfg.data;
        REG_KEY_WORD1: key_word[1] <= cfg.data;
        REG_KEY_WORD2: key_word[2] <= cfg.data;
        REG_KEY_WORD3: key_word[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  // One key word per cycle; win[0] holds the newest word.
  assign key_w      = widx[0] ? key_word[widx[2:1]][31:0] : key_word[widx[2:1]][63:32];
  assign first_word = key_mode ? (widx < 6'd8) : (widx < 6'd4);
  assign rot_step   = key_mode ? (widx[2:0] == 3'd0) : (widx[1:0] == 2'd0);
  assign sub_step   = key_mode && (widx[2:0] == 3'd4);
  assign done_step  = (widx == (key_mode ? 6'd59 : 6'd43));

  always_comb begin
    t = win[0];
    if (rot_step) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
    end else if (sub_step) begin
      t = sub_word(t);
    end
    word = first_word ? key_w : ((key_mode ? win[7] : win[3]) ^ t);
  end

  // Restart the expansion on every config write.
  always_ff @(posedge clk) begin
    if (rst || cfg.valid) begin
      busy <= 1'b1;
      widx <= '0;
      rc   <= 8'h01;
    end else if (busy) begin
      for (int k = 7; k > 0; k--) win[k] <= win[k-1];
      win[0] <= word;
      round_keys[widx[5:2]][7'd127 - {widx[1:0], 5'd0} -: 32] <= word;
      if (!first_word && rot_step) rc <= xtime(rc);
      widx <= widx + 6'd1;
      if (done_step) busy <= 1'b0;
    end
  end

endmodule

@@ design/aes_round.sv @@
// One registered AES round stage with valid and stall control.
// Depends on aes_pkg.
`timescale 1ns / 1ps
module aes_round
  import aes_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  logic   in_valid,
  input  block_t in_state,
  input  block_t round_key,
  input  logic   last,
  output logic   out_valid,
  output block_t out_state
);

  block_t shifted;
  block_t mixed;

  assign shifted = sub_shift(in_state);
  assign mixed   = last ? shifted : mix_columns(shifted);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state <= mixed ^ round_key;
    end
  end

endmodule

@@ design/aes_block_encryptor.sv @@
// Top level of the AES-128/256 block encryptor: key schedule plus unrolled
// round pipeline. Depends on aes_pkg, aes_if, aes_key_sched, aes_round.
`timescale 1ns / 1ps
// Accepts one 128-bit block per cycle while the pipe advances and the keys
// are ready and returns its ciphertext: one stage for the initial key add
// and one per round, 14 rounds unrolled. In AES-128 mode the last round is
// taken at stage 10 and the block rides the remaining stages as a pass-through
// to the same final stage as in AES-256. The whole pipe stalls when the
// output is held. After reset and after every key or mode write the round
// keys are rebuilt one key word per cycle, and the input is held off until
// they are done. Write keys only while no block is in flight.
module aes_block_encryptor
  import aes_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  aes_cfg_if.sink       cfg,
  aes_plain_if.sink     plain,
  aes_cipher_if.source  cipher
);

  logic   key_mode;
  logic   key_ready;
  block_t round_keys [NumStages];
  logic   stage_valid [NumStages];
  block_t stage_state [NumStages];
  logic   advance;

  aes_key_sched u_key (
    .clk, .rst, .cfg, .key_mode, .key_ready, .round_keys
  );

  // Pipe moves when the output register is empty or being drained.
  assign advance     = !stage_valid[NumStages-1] || cipher.ready;
  assign plain.ready = advance && key_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else if (advance) begin
      stage_valid[0] <= plain.valid && key_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_state[0] <= {plain.plain_high, plain.plain_low} ^ round_keys[0];
    end
  end

  for (genvar r = 1; r < NumStages; r++) begin : g_round
    logic   bypass;
    logic   last;
    block_t round_out;
    assign bypass = !key_mode && (r > 10);
    assign last   = key_mode ? (r == 14) : (r == 10);
    aes_round u_round (
      .clk, .rst, .advance,
      .in_valid  (stage_valid[r-1]),
      .in_state  (stage_state[r-1]),
      .round_key (round_keys[r]),
      .last,
      .out_valid (stage_valid[r]),
      .out_state (round_out)
    );
    // AES-128 blocks skip the four trailing rounds through a plain register.
    logic   bypass_d;
    block_t pass_state;
    always_ff @(posedge clk) begin
      if (advance) begin
        pass_state <= stage_state[r-1];
        bypass_d   <= bypass;
      end
    end
    assign stage_state[r] = bypass_d ? pass_state : round_out;
  end

  assign cipher.valid       = stage_valid[NumStages-1];
  assign cipher.cipher_high = stage_state[NumStages-1][127:64];
  assign cipher.cipher_low  = stage_state[NumStages-1][63:0];

endmodule
